// ===== design/igmpq_pkg.sv =====
package igmpq_pkg;

	// frame geometry
	localparam int FRAME_BYTES = 60;
	localparam int IDX_W = $clog2(FRAME_BYTES);

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_DEST_GROUP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TTL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_SECONDS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_V3_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC = 3'd4;

	// register reset values
	localparam logic [31:0] RST_DEST_GROUP = 32'hE000_0001;
	localparam logic [7:0] RST_TTL = 8'd1;
	localparam logic [7:0] RST_RESP_SECONDS = 8'd1;
	localparam logic RST_V3_MODE = 1'b0;
	localparam logic [47:0] RST_SOURCE_MAC = 48'h0024_981D_37E8;

	// fixed header fields
	localparam logic [7:0] MCAST_OUI_LO = 8'h5E;
	localparam logic [7:0] MCAST_MAC_MASK = 8'h7F;
	localparam logic [7:0] IP_VER_IHL = 8'h46;
	localparam logic [7:0] IP_LEN_V2 = 8'd32;
	localparam logic [7:0] IP_LEN_V3 = 8'd36;
	localparam logic [7:0] IP_ID_LO = 8'h95;
	localparam logic [7:0] IP_PROTO_IGMP = 8'h02;
	localparam logic [7:0] RTR_ALERT_TYPE = 8'h94;
	localparam logic [7:0] RTR_ALERT_LEN = 8'h04;
	localparam logic [7:0] IGMP_TYPE_QUERY = 8'h11;
	localparam logic [7:0] IGMP_V3_QQIC = 8'h0A;
	localparam logic [7:0] PAD_BYTE = 8'h55;
	localparam logic [7:0] ETYPE_HI = 8'h08;

	// sum of the ip header words that never change: 4600 + 0095 + 9404
	localparam logic [15:0] IP_FIXED_SUM = 16'hDA99;

	typedef struct packed {
		logic [31:0] dest_group;
		logic [7:0] ttl;
		logic [7:0] resp_seconds;
		logic v3_mode;
		logic [47:0] source_mac;
	} cfg_t;

	typedef struct packed {
		logic [31:0] source_ip;
		logic [15:0] ip_cksum;
		logic [15:0] igmp_cksum;
		logic [7:0] max_resp;
	} frame_t;

endpackage

// ===== design/igmpq_cksum.sv =====
module igmpq_cksum (
	input logic clk,
	input logic arst_n,
	input igmpq_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input logic [31:0] source_ip,
	output logic out_valid,
	input logic out_ready,
	output igmpq_pkg::frame_t out_frame
);

	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	logic [31:0] src_s1, src_s2, src_s3;
	logic [16:0] src_sum_s1;
	logic [17:0] cfg_sum_s1;
	logic [7:0] mrc_s2, mrc_s3;
	logic [16:0] fold_s2;
	logic [15:0] ip_ck_s3, ig_ck_s3;

	logic [18:0] total;
	logic [7:0] mrc;
	logic [16:0] fold2;
	logic [15:0] ig_sum;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// ten times the response time, wrapped
	assign mrc = {cfg.resp_seconds[4:0], 3'b000} + {cfg.resp_seconds[6:0], 1'b0};
	assign total = 19'(src_sum_s1) + 19'(cfg_sum_s1);
	assign fold2 = 17'(fold_s2[15:0]) + 17'(fold_s2[16]);
	assign ig_sum = {igmpq_pkg::IGMP_TYPE_QUERY, mrc_s2}
		+ (cfg.v3_mode ? 16'(igmpq_pkg::IGMP_V3_QQIC) : 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			src_s1 <= source_ip;
			src_sum_s1 <= 17'(source_ip[31:16]) + 17'(source_ip[15:0]);
			cfg_sum_s1 <= 18'(cfg.dest_group[31:16]) + 18'(cfg.dest_group[15:0])
				+ 18'({cfg.ttl, igmpq_pkg::IP_PROTO_IGMP})
				+ 18'(igmpq_pkg::IP_FIXED_SUM)
				+ 18'(cfg.v3_mode ? igmpq_pkg::IP_LEN_V3 : igmpq_pkg::IP_LEN_V2);
		end
		if (ready_s2 && valid_s1) begin
			src_s2 <= src_s1;
			fold_s2 <= 17'(total[15:0]) + 17'(total[18:16]);
			mrc_s2 <= mrc;
		end
		if (ready_s3 && valid_s2) begin
			src_s3 <= src_s2;
			mrc_s3 <= mrc_s2;
			ip_ck_s3 <= ~fold2[15:0];
			ig_ck_s3 <= ~ig_sum;
		end
	end

	assign out_valid = valid_s3;
	assign out_frame.source_ip = src_s3;
	assign out_frame.ip_cksum = ip_ck_s3;
	assign out_frame.igmp_cksum = ig_ck_s3;
	assign out_frame.max_resp = mrc_s3;

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_ready |=> valid_s3 && $stable(ip_ck_s3) && $stable(src_s3))
		else $error("checksum stage lost a stalled frame");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_s2 |=> valid_s2 && $stable(fold_s2))
		else $error("fold stage changed while stalled");

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && valid_s3)
		else $error("input stalled with a free stage");

endmodule

// ===== design/igmpq_ser.sv =====
module igmpq_ser (
	input logic clk,
	input logic arst_n,
	input igmpq_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input igmpq_pkg::frame_t in_frame,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] frame_byte,
	output logic is_last
);

	localparam logic [igmpq_pkg::IDX_W-1:0] LAST_IDX =
		igmpq_pkg::IDX_W'(igmpq_pkg::FRAME_BYTES - 1);

	logic frame_valid_q;
	logic [igmpq_pkg::IDX_W-1:0] idx_q;
	igmpq_pkg::frame_t frame_q;
	logic out_valid_q;
	logic [7:0] byte_q;
	logic last_q;

	logic out_load, last_byte, take;
	logic [7:0] next_byte;

	assign out_load = frame_valid_q && (!out_valid_q || !out_stall);
	assign last_byte = idx_q == LAST_IDX;
	assign take = !frame_valid_q || (out_load && last_byte);
	assign in_ready = take;

	always_comb begin
		unique case (idx_q)
			6'd0: next_byte = 8'h01;
			6'd2: next_byte = igmpq_pkg::MCAST_OUI_LO;
			6'd3: next_byte = cfg.dest_group[23:16] & igmpq_pkg::MCAST_MAC_MASK;
			6'd4: next_byte = cfg.dest_group[15:8];
			6'd5: next_byte = cfg.dest_group[7:0];
			6'd6: next_byte = cfg.source_mac[47:40];
			6'd7: next_byte = cfg.source_mac[39:32];
			6'd8: next_byte = cfg.source_mac[31:24];
			6'd9: next_byte = cfg.source_mac[23:16];
			6'd10: next_byte = cfg.source_mac[15:8];
			6'd11: next_byte = cfg.source_mac[7:0];
			6'd12: next_byte = igmpq_pkg::ETYPE_HI;
			6'd14: next_byte = igmpq_pkg::IP_VER_IHL;
			6'd17: next_byte = cfg.v3_mode ? igmpq_pkg::IP_LEN_V3 : igmpq_pkg::IP_LEN_V2;
			6'd19: next_byte = igmpq_pkg::IP_ID_LO;
			6'd22: next_byte = cfg.ttl;
			6'd23: next_byte = igmpq_pkg::IP_PROTO_IGMP;
			6'd24: next_byte = frame_q.ip_cksum[15:8];
			6'd25: next_byte = frame_q.ip_cksum[7:0];
			6'd26: next_byte = frame_q.source_ip[31:24];
			6'd27: next_byte = frame_q.source_ip[23:16];
			6'd28: next_byte = frame_q.source_ip[15:8];
			6'd29: next_byte = frame_q.source_ip[7:0];
			6'd30: next_byte = cfg.dest_group[31:24];
			6'd31: next_byte = cfg.dest_group[23:16];
			6'd32: next_byte = cfg.dest_group[15:8];
			6'd33: next_byte = cfg.dest_group[7:0];
			6'd34: next_byte = igmpq_pkg::RTR_ALERT_TYPE;
			6'd35: next_byte = igmpq_pkg::RTR_ALERT_LEN;
			6'd38: next_byte = igmpq_pkg::IGMP_TYPE_QUERY;
			6'd39: next_byte = frame_q.max_resp;
			6'd40: next_byte = frame_q.igmp_cksum[15:8];
			6'd41: next_byte = frame_q.igmp_cksum[7:0];
			6'd47: next_byte = cfg.v3_mode ? igmpq_pkg::IGMP_V3_QQIC : 8'h00;
			6'd48, 6'd49: next_byte = cfg.v3_mode ? 8'h00 : igmpq_pkg::PAD_BYTE;
			6'd1, 6'd13, 6'd15, 6'd16, 6'd18, 6'd20, 6'd21, 6'd36, 6'd37,
			6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd50, 6'd51: next_byte = 8'h00;
			default: next_byte = igmpq_pkg::PAD_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && in_valid) begin
				frame_valid_q <= 1'b1;
				idx_q <= '0;
			end else if (out_load && last_byte) begin
				frame_valid_q <= 1'b0;
				idx_q <= '0;
			end else if (out_load) begin
				idx_q <= idx_q + igmpq_pkg::IDX_W'(1);
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) frame_q <= in_frame;
		if (out_load) begin
			byte_q <= next_byte;
			last_q <= last_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_byte = byte_q;
	assign is_last = last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid_q |-> idx_q <= LAST_IDX)
		else $error("byte index past end of frame");

	a_last_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> byte_q == igmpq_pkg::PAD_BYTE)
		else $error("last byte is not trailer pad");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && last_byte |=> idx_q == '0)
		else $error("index did not restart after last byte");

endmodule

// ===== design/igmp_query_frame_builder.sv =====
// igmp general query frame builder: every request carrying a source ipv4 address
// yields one 60-byte ethernet frame, one byte per output request in wire order,
// with is_last on the sixtieth byte. a three-stage pipeline forms the ipv4 header
// and igmp checksums, then a byte serializer with a registered output walks the
// frame. the serializer is one byte wide and takes the next frame as it loads
// the last byte of the current one, so frames leave back to back whenever the
// output does not stall; a request waits in the checksum stages meanwhile. up
// to three further requests are held in the checksum pipeline while a frame is
// being sent. configuration writes are always taken (cfg_ready is tied high);
// index 0 destination group, 1 ttl, 2 response seconds, 3 v3 mode, 4 source mac,
// other indexes are ignored. configuration must only change while no frame is
// pending or in flight.
module igmp_query_frame_builder (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [31:0] source_ip,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] frame_byte,
	output logic is_last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [igmpq_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [igmpq_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	igmpq_pkg::cfg_t cfg_q;

	// checksum pipeline to serializer
	logic ck_valid, ck_ready, in_ready;
	igmpq_pkg::frame_t ck_frame;

	assign cfg_ready = 1'b1;
	assign in_stall = !in_ready;

	// register file, low bits of the data kept per register width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_group <= igmpq_pkg::RST_DEST_GROUP;
			cfg_q.ttl <= igmpq_pkg::RST_TTL;
			cfg_q.resp_seconds <= igmpq_pkg::RST_RESP_SECONDS;
			cfg_q.v3_mode <= igmpq_pkg::RST_V3_MODE;
			cfg_q.source_mac <= igmpq_pkg::RST_SOURCE_MAC;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				igmpq_pkg::REG_DEST_GROUP: cfg_q.dest_group <= cfg_data[31:0];
				igmpq_pkg::REG_TTL: cfg_q.ttl <= cfg_data[7:0];
				igmpq_pkg::REG_RESP_SECONDS: cfg_q.resp_seconds <= cfg_data[7:0];
				igmpq_pkg::REG_V3_MODE: cfg_q.v3_mode <= cfg_data[0];
				igmpq_pkg::REG_SOURCE_MAC: cfg_q.source_mac <= cfg_data[47:0];
				// unused indexes: write dropped
				default: begin
				end
			endcase
		end
	end

	// header and igmp checksums, three register stages
	igmpq_cksum u_cksum (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.source_ip(source_ip),
		.out_valid(ck_valid),
		.out_ready(ck_ready),
		.out_frame(ck_frame)
	);

	// byte serializer with output register
	igmpq_ser u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(ck_valid),
		.in_ready(ck_ready),
		.in_frame(ck_frame),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_byte(frame_byte),
		.is_last(is_last)
	);

endmodule

// ===== test/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles of settling after the last expected byte, longer than the pipe latency
	localparam int DRAIN_CYCLES = 8;
	// receiver hold-off used to fill the checksum pipe and force input stall
	localparam int HOLD_CYCLES = 400;
	// cycles with no handshake on any channel before the run is declared hung
	localparam int QUIET_LIMIT = 4000;
	// register widths, indexed by register code
	localparam int REG_WIDTH [5] = '{32, 8, 8, 1, 48};

	typedef struct {
		logic [7:0] data_byte;
		logic last_flag;
	} frame_octet_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [31:0] source_ip;
	logic out_valid;
	logic out_stall;
	logic [7:0] frame_byte;
	logic is_last;
	logic cfg_valid;
	logic cfg_ready;
	logic [igmpq_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [igmpq_pkg::CFG_DATA_W-1:0] cfg_data;

	// shadow copy of the configuration registers, updated on each accepted write
	igmpq_pkg::cfg_t cfg_shadow;
	// bytes still owed by the block, oldest first
	frame_octet_t expected_bytes [$];

	int error_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	logic hold_off;
	int quiet_cycles = 0;

	igmp_query_frame_builder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.source_ip(source_ip),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_byte(frame_byte),
		.is_last(is_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------------------
	// frame prediction
	// ---------------------------------------------------------------------------

	// internet checksum over big-endian 16-bit words, full end-around carry
	function automatic logic [15:0] inet_cksum(input logic [7:0] f [igmpq_pkg::FRAME_BYTES],
			input int first, input int len);
		logic [31:0] acc;
		acc = 32'd0;
		for (int k = 0; k + 1 < len; k += 2)
			acc += {16'd0, f[first+k], f[first+k+1]};
		acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
		acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
		return ~acc[15:0];
	endfunction

	// whole 60-byte query frame for one source address under configuration c
	function automatic void build_query_frame(input igmpq_pkg::cfg_t c, input logic [31:0] ip,
			output logic [7:0] f [igmpq_pkg::FRAME_BYTES]);
		logic [15:0] ck;
		logic [7:0] max_resp;
		for (int k = 0; k < igmpq_pkg::FRAME_BYTES; k++)
			f[k] = 8'h00;

		// ethernet: multicast mac keeps only the low 23 bits of the group
		f[0] = 8'h01;
		f[1] = 8'h00;
		f[2] = 8'h5E;
		f[3] = {1'b0, c.dest_group[22:16]};
		f[4] = c.dest_group[15:8];
		f[5] = c.dest_group[7:0];
		for (int k = 0; k < 6; k++)
			f[6+k] = c.source_mac[47-8*k -: 8];
		f[12] = 8'h08;
		f[13] = 8'h00;

		// ipv4 header, 24 bytes with router alert option
		f[14] = 8'h46;
		f[17] = c.v3_mode ? 8'd36 : 8'd32;
		f[19] = 8'h95;
		f[22] = c.ttl;
		f[23] = 8'h02;
		for (int k = 0; k < 4; k++) begin
			f[26+k] = ip[31-8*k -: 8];
			f[30+k] = c.dest_group[31-8*k -: 8];
		end
		f[34] = 8'h94;
		f[35] = 8'h04;
		ck = inet_cksum(f, 14, 24);
		f[24] = ck[15:8];
		f[25] = ck[7:0];

		// igmp query; max response code wraps to 8 bits
		max_resp = c.resp_seconds * 8'd10;
		f[38] = 8'h11;
		f[39] = max_resp;
		if (c.v3_mode) begin
			f[47] = 8'h0A;
			ck = inet_cksum(f, 38, 12);
		end else begin
			ck = inet_cksum(f, 38, 8);
			f[48] = 8'h55;
			f[49] = 8'h55;
		end
		f[40] = ck[15:8];
		f[41] = ck[7:0];

		// trailer: two zero bytes then pad
		for (int k = 52; k < igmpq_pkg::FRAME_BYTES; k++)
			f[k] = 8'h55;
	endfunction

	// ---------------------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------------------

	// offer one query request, idling at random first; on acceptance queue its frame
	task automatic offer_query(input logic [31:0] ip);
		logic [7:0] frame [igmpq_pkg::FRAME_BYTES];
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		source_ip <= ip;
		do @(posedge clk); while (in_stall);
		build_query_frame(cfg_shadow, ip, frame);
		for (int k = 0; k < igmpq_pkg::FRAME_BYTES; k++)
			expected_bytes.push_back('{frame[k], k == igmpq_pkg::FRAME_BYTES - 1});
	endtask

	function automatic logic [31:0] random_source_ip();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// stop offering and wait until every owed byte has come out
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------------
	// configuration side
	// ---------------------------------------------------------------------------

	// one register write; cfg_valid stays high so back-to-back writes need no toggle
	task automatic write_reg(input logic [igmpq_pkg::CFG_IDX_W-1:0] idx,
			input logic [igmpq_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		// only the low bits of each register's width are kept
		case (idx)
			igmpq_pkg::REG_DEST_GROUP: cfg_shadow.dest_group = data[31:0];
			igmpq_pkg::REG_TTL: cfg_shadow.ttl = data[7:0];
			igmpq_pkg::REG_RESP_SECONDS: cfg_shadow.resp_seconds = data[7:0];
			igmpq_pkg::REG_V3_MODE: cfg_shadow.v3_mode = data[0];
			igmpq_pkg::REG_SOURCE_MAC: cfg_shadow.source_mac = data[47:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] dest, input logic [7:0] ttl,
			input logic [7:0] resp, input logic v3, input logic [47:0] mac);
		settle();
		write_reg(igmpq_pkg::REG_DEST_GROUP, igmpq_pkg::CFG_DATA_W'(dest));
		write_reg(igmpq_pkg::REG_TTL, igmpq_pkg::CFG_DATA_W'(ttl));
		write_reg(igmpq_pkg::REG_RESP_SECONDS, igmpq_pkg::CFG_DATA_W'(resp));
		write_reg(igmpq_pkg::REG_V3_MODE, igmpq_pkg::CFG_DATA_W'(v3));
		write_reg(igmpq_pkg::REG_SOURCE_MAC, igmpq_pkg::CFG_DATA_W'(mac));
		end_writes();
	endtask

	// zero, all ones or random within the width, sometimes with junk above it
	function automatic logic [igmpq_pkg::CFG_DATA_W-1:0] pick_reg_value(input int width);
		logic [47:0] full;
		logic [47:0] mask;
		logic [47:0] v;
		full = {16'($urandom()), 32'($urandom())};
		mask = (48'd1 << width) - 48'd1;
		case ($urandom_range(3))
			0: v = 48'd0;
			1: v = mask;
			default: v = full & mask;
		endcase
		if (width < 48 && $urandom_range(3) == 0)
			v |= full & ~mask;
		return v;
	endfunction

	task automatic randomize_config();
		settle();
		for (int r = igmpq_pkg::REG_DEST_GROUP; r <= igmpq_pkg::REG_SOURCE_MAC; r++)
			write_reg(igmpq_pkg::CFG_IDX_W'(r), pick_reg_value(REG_WIDTH[r]));
		// now and then poke an index that has no register behind it
		if ($urandom_range(3) == 0)
			write_reg(igmpq_pkg::CFG_IDX_W'($urandom_range(2**igmpq_pkg::CFG_IDX_W - 1,
				igmpq_pkg::REG_SOURCE_MAC + 1)), {16'($urandom()), 32'($urandom())});
		end_writes();
	endtask

	// ---------------------------------------------------------------------------
	// result side: random stall plus an optional long hold-off
	// ---------------------------------------------------------------------------

	// hold-off counter lives in its own process; a test bumps hold_requests to start one
	initial begin
		hold_off = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			hold_off = hold_left > 0;
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= hold_off || ($urandom_range(99) < stall_pct);
		end
	end

	// every accepted byte is matched against the oldest owed byte
	always @(posedge clk) begin : check_bytes
		frame_octet_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				error_count++;
				$display("%0t: unexpected byte, expected none actual %02h last %0b",
					$time, frame_byte, is_last);
			end else begin
				want = expected_bytes.pop_front();
				if (frame_byte !== want.data_byte) begin
					error_count++;
					$display("%0t: frame_byte mismatch, expected %02h actual %02h",
						$time, want.data_byte, frame_byte);
				end
				if (is_last !== want.last_flag) begin
					error_count++;
					$display("%0t: is_last mismatch, expected %0b actual %0b",
						$time, want.last_flag, is_last);
				end
			end
		end
	end

	// hang detector: any handshake on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------------

	// reset configuration: 224.0.0.1, ttl 1, one second, v2 layout
	task automatic test_reset_defaults();
		send_idle_pct = 0;
		stall_pct = 0;
		offer_query(32'h0000_0000);
		offer_query(32'hFFFF_FFFF);
		offer_query(32'h8000_0001);
		offer_query(32'h7FFF_FFFE);
	endtask

	// every register at its lowest and highest value, both layouts
	task automatic test_config_extremes();
		set_config(32'h0, 8'h00, 8'h00, 1'b0, 48'h0);
		offer_query(32'h0000_0000);
		set_config(32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, 48'hFFFF_FFFF_FFFF);
		offer_query(32'hFFFF_FFFF);
		set_config(32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0, 48'hFFFF_FFFF_FFFF);
		offer_query(32'h8000_0001);
		set_config(32'h0, 8'h00, 8'h00, 1'b1, 48'h0);
		offer_query(32'h7FFF_FFFE);
	endtask

	// max response code just below and above the 8-bit wrap, and at the top
	task automatic test_response_wrap();
		set_config(32'hE000_0001, 8'd1, 8'd25, 1'b0, 48'h0024_981D_37E8);
		offer_query(random_source_ip());
		set_config(32'hE000_0001, 8'd1, 8'd26, 1'b1, 48'h0024_981D_37E8);
		offer_query(random_source_ip());
		set_config(32'hE000_0001, 8'd1, 8'd255, 1'b0, 48'h0024_981D_37E8);
		offer_query(random_source_ip());
	endtask

	// top bit of the group's second octet must not reach the mac
	task automatic test_multicast_mapping();
		set_config(32'hEFFF_FFFF, 8'd64, 8'd10, 1'b1, 48'h0200_0000_0001);
		offer_query(32'hC0A8_0001);
		set_config(32'hE07F_0000, 8'd64, 8'd10, 1'b0, 48'h0200_0000_0001);
		offer_query(32'h0A00_0001);
	endtask

	// writes to unused indexes change nothing; wide data is cut to the register width
	task automatic test_ignored_writes();
		settle();
		for (int r = igmpq_pkg::REG_SOURCE_MAC + 1; r < 2**igmpq_pkg::CFG_IDX_W; r++)
			write_reg(igmpq_pkg::CFG_IDX_W'(r), 48'hFFFF_FFFF_FFFF);
		write_reg(igmpq_pkg::REG_TTL, 48'hFFFF_FFFF_FF12);
		write_reg(igmpq_pkg::REG_V3_MODE, 48'hFFFF_FFFF_FFFE);
		write_reg(igmpq_pkg::REG_RESP_SECONDS, 48'hABCD_EF01_2333);
		write_reg(igmpq_pkg::REG_DEST_GROUP, 48'hABCD_E123_4567);
		end_writes();
		offer_query(32'h1234_5678);
		offer_query(32'hEDCB_A987);
	endtask

	// random addresses under a fresh random configuration every 20 requests
	task automatic test_random_queries(input int count, input int send_pct, input int rx_pct);
		send_idle_pct = send_pct;
		stall_pct = rx_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 20 == 0)
				randomize_config();
			offer_query(random_source_ip());
		end
		settle();
	endtask

	// receiver holds off while requests keep coming, so the pipe fills and stalls input
	task automatic test_backpressure();
		settle();
		send_idle_pct = 0;
		stall_pct = 0;
		@(negedge clk);
		hold_requests++;
		repeat (10) offer_query(random_source_ip());
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		source_ip = 32'd0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_shadow = '{32'hE000_0001, 8'd1, 8'd1, 1'b0, 48'h0024_981D_37E8};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_config_extremes();
		test_response_wrap();
		test_multicast_mapping();
		test_ignored_writes();
		// sender mostly busy while the receiver stalls heavily, then the reverse, then flat out
		test_random_queries(100, 13, 59);
		test_random_queries(100, 59, 13);
		test_random_queries(100, 0, 0);
		test_backpressure();

		settle();
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
